@@ hw/rtl/tdpt_pkg.sv @@
// Shared types and constants for the trial-division prime test.
`timescale 1ns / 1ps

package tdpt_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_NEXT,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture a new value, divisor back to 2
      logic div_start;  // clear remainder, arm bit counter
      logic div_step;   // one restoring-division bit
      logic advance;    // next divisor and its square
      logic emit;       // write result register
      logic verdict;    // value written on emit
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic trivial;    // negative, zero or one
      logic past_root;  // divisor squared exceeds value
      logic div_done;   // last division bit this cycle
      logic rem_zero;   // remainder is zero
      logic out_free;   // result register can take a beat
   } ctrl_sts_type;

endpackage

@@ hw/rtl/tdpt_datapath.sv @@
// Datapath: value, divisor, running square, bit-serial remainder, result register.
`timescale 1ns / 1ps

module tdpt_datapath #(
   parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tdpt_pkg::ctrl_cmd_type   cmd,
   output tdpt_pkg::ctrl_sts_type   sts,
   input  logic [VALUE_BITS-1:0]    req_number,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_is_prime
);

   localparam int unsigned CW = $clog2(VALUE_BITS);
   localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

   logic [VALUE_BITS-1:0] n_ff, d_ff, d_in, sq_ff, sq_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] trial;
   logic                  valid_ff, valid_in, prime_ff, prime_in;

   // trial remainder: shift one dividend bit in
   assign trial = {rem_ff[VALUE_BITS-2:0], dvd_ff[VALUE_BITS-1]};

   always_comb begin
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         d_in  = VALUE_BITS'(2);
         sq_in = VALUE_BITS'(4);
      end else if (cmd.advance) begin
         d_in  = d_ff + VALUE_BITS'(1);
         sq_in = sq_ff + {d_ff[VALUE_BITS-2:0], 1'b1};   // (d+1)^2 = d^2 + 2d + 1
      end
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = n_ff;
         cnt_in = LAST_BIT;
      end else if (cmd.div_step) begin
         rem_in = (trial >= d_ff) ? trial - d_ff : trial;
         dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= req_number;
      end
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   // result register
   always_comb begin
      valid_in = valid_ff;
      prime_in = prime_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         prime_in = cmd.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prime_ff <= prime_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

   assign sts.trivial   = n_ff[VALUE_BITS-1] || (n_ff[VALUE_BITS-1:1] == '0);
   assign sts.past_root = sq_ff > n_ff;
   assign sts.div_done  = (cnt_ff == '0);
   assign sts.rem_zero  = (rem_ff == '0);
   assign sts.out_free  = !valid_ff || !rsp_stall;

endmodule

@@ hw/rtl/tdpt_ctrl.sv @@
// Controller state machine: sequences bound checks and divisions.
`timescale 1ns / 1ps

module tdpt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tdpt_pkg::ctrl_sts_type   sts,
   output tdpt_pkg::ctrl_cmd_type   cmd
);

   tdpt_pkg::state_type state_ff, state_in;
   logic                verdict_ff, verdict_in;

   // next state
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tdpt_pkg::ST_TEST;
            end
         end
         tdpt_pkg::ST_TEST: begin
            if (sts.trivial) begin
               verdict_in = 1'b0;
               state_in   = tdpt_pkg::ST_EMIT;
            end else if (sts.past_root) begin
               verdict_in = 1'b1;
               state_in   = tdpt_pkg::ST_EMIT;
            end else begin
               state_in = tdpt_pkg::ST_DIV;
            end
         end
         tdpt_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = tdpt_pkg::ST_NEXT;
            end
         end
         tdpt_pkg::ST_NEXT: begin
            if (sts.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = tdpt_pkg::ST_EMIT;
            end else begin
               state_in = tdpt_pkg::ST_TEST;
            end
         end
         tdpt_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               state_in = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cmd.verdict = verdict_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tdpt_pkg::ST_TEST: begin
            cmd.div_start = !sts.trivial && !sts.past_root;
         end
         tdpt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         tdpt_pkg::ST_NEXT: begin
            cmd.advance = !sts.rem_zero;
         end
         tdpt_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      verdict_ff <= verdict_in;
   end

`ifndef SYNTHESIS
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written while result register is held");

   a_div_ends_in_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdpt_pkg::ST_DIV) && sts.div_done |=> (state_ff == tdpt_pkg::ST_NEXT))
      else $error("division did not end after its last bit");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.advance, cmd.emit}))
      else $error("more than one datapath command at once");

   a_load_starts_test: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == tdpt_pkg::ST_TEST))
      else $error("accepted beat not followed by a bound check");
`endif

endmodule

@@ hw/rtl/trial_division_prime_test.sv @@
// Top level: trial-division primality test of one signed value per beat.
`timescale 1ns / 1ps

// Usage
//   req channel: req_valid / req_stall / req_number. A beat is taken when
//   req_valid is high and req_stall is low. req_number is read as a two's
//   complement value VALUE_BITS wide.
//   rsp channel: rsp_valid / rsp_stall / rsp_is_prime. One beat per request,
//   in order; rsp_is_prime = 1 when the value is prime.
// Operation
//   One value at a time. Values below two or negative go from the bound
//   check straight to the result. Otherwise each trial divisor takes a bound
//   check, a bit-serial restoring remainder of VALUE_BITS bits, and a
//   remainder check that also steps the divisor and its square; a prime runs
//   this for every divisor from 2 up to floor(sqrt(value)). The remainder
//   loop dominates the run time.
// Reset
//   Synchronous, active high; drops any item in flight and any pending result.
// Backpressure
//   The result sits in an output register. While it is stalled the block
//   still takes and works on the next value; it waits only when that next
//   result is ready and the register is still occupied.

module trial_division_prime_test #(
   parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_prime
);

   tdpt_pkg::ctrl_cmd_type cmd;
   tdpt_pkg::ctrl_sts_type sts;

   // sequencing: accept, bound check, divide, step divisor, emit
   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // value, divisor, square, remainder unit and result register
   tdpt_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the trial-division prime test block.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned W = tdpt_pkg::VALUE_BITS_DEFAULT;

   // Cycles without any accepted beat before the run is declared hung. The
   // slowest value sent here is the prime 16777213, with 4094 trial divisors.
   // The limit covers its test four times over.
   localparam int unsigned HANG_LIMIT = 600_000;

   // Items per random phase; four phases give about eighty random items.
   localparam int unsigned PHASE_ITEMS = 20;

   // ------------------------------------------------------------------
   // Expected verdicts, oldest first, with their own primality predictor.
   // ------------------------------------------------------------------
   class prime_scoreboard #(int unsigned NB = 32);
      bit            pending_verdicts[$];
      logic [NB-1:0] pending_numbers[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Sign bit set, zero and one are never prime. Otherwise try every
      // divisor up to the square root; d <= v / d avoids overflow of d * d.
      function bit primality_of(logic [NB-1:0] n);
         longint unsigned v;
         longint unsigned d;
         if (n[NB-1]) return 1'b0;
         v = 64'(n);
         if (v <= 1) return 1'b0;
         for (d = 2; d <= v / d; d++) begin
            if (v % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      task report_mismatch(string what);
         $display("%0t ns mismatch: %s", $time, what);
         mismatches++;
      endtask

      function void note_number(logic [NB-1:0] n);
         pending_numbers.push_back(n);
         pending_verdicts.push_back(primality_of(n));
      endfunction

      task check_verdict(logic got);
         bit            want;
         logic [NB-1:0] n;
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("is_prime=%b with no request waiting", got));
         end else begin
            want = pending_verdicts.pop_front();
            n    = pending_numbers.pop_front();
            if (got !== want)
               report_mismatch($sformatf("number %0d (0x%h): is_prime=%b, want %b",
                                         $signed(n), n, got, want));
         end
      endtask

      function int unsigned pending_count();
         return pending_verdicts.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, block inputs (known from time zero) and the instance.
   // ------------------------------------------------------------------
   logic         clock;
   logic         reset      = 1'b1;
   logic         req_valid  = 1'b0;
   logic         req_stall;
   logic [W-1:0] req_number = '0;
   logic         rsp_valid;
   logic         rsp_stall  = 1'b0;
   logic         rsp_is_prime;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   trial_division_prime_test #(.VALUE_BITS(W)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   prime_scoreboard #(W) sb;

   // Percent chance per cycle that the sender idles / the receiver stalls.
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;

   // Hand-picked values: both ends of the range, the trivial cases, the
   // smallest primes, squares of primes (divisor lands exactly on the root),
   // a semiprime of two close primes, and a few slow but bounded primes.
   // The largest positive value is itself a prime whose test would step
   // through every divisor up to 46340, so the top of the range is covered
   // by its odd and even neighbors instead.
   logic [W-1:0] corner_numbers[$] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
      32'd97, 32'd121, 32'd65537, 32'd1018081, 32'd1022117, 32'd1000003,
      32'd16777213, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555, 32'h2AAA_AAAA
   };

   // ------------------------------------------------------------------
   // Request side: one beat per call, with random idle cycles ahead of it.
   // A beat is taken at the edge where valid was high and stall was low;
   // values sampled right after the edge are the pre-edge ones.
   // ------------------------------------------------------------------
   task send_number(logic [W-1:0] n);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid  <= 1'b0;
         req_number <= $urandom();   // junk while idle, must be ignored
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= n;
      do @(posedge clock); while (req_stall);
      sb.note_number(n);
   endtask

   // Random mix. Large positive values are built as a small factor times a
   // random cofactor, so their test ends within a few dozen divisors; small
   // and mid-sized values give the real primes; negatives take the sign path.
   function logic [W-1:0] pick_number();
      int unsigned  kind;
      int unsigned  factor;
      logic [W-1:0] n;
      kind = $urandom_range(99);
      if (kind < 28) begin
         n = $urandom() | 32'h8000_0000;
      end else if (kind < 60) begin
         n = $urandom_range(65535);
      end else if (kind < 72) begin
         n = $urandom_range(32'h000F_FFFF);
      end else begin
         factor = $urandom_range(47, 2);
         n = factor * $urandom_range(32'h7FFF_FFFF / factor, 2);
      end
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Result side: check every accepted beat, stall at random.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_is_prime);
         rsp_stall <= receiver_stall_pct != 0 &&
                      $urandom_range(99) < receiver_stall_pct;
      end
   end

   // ------------------------------------------------------------------
   // Hang watchdog: counts cycles in which neither channel moves a beat.
   // ------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("%0t ns timeout: no beat for %0d cycles", $time, HANG_LIMIT);
         $display("trial_division_prime_test regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      int unsigned phase;
      int unsigned k;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed values, no idling on either side.
      foreach (corner_numbers[i]) send_number(corner_numbers[i]);

      // Random phases: none, sender idling, receiver stalling, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
         endcase
         for (k = 0; k < PHASE_ITEMS; k++) send_number(pick_number());
      end
      req_valid <= 1'b0;

      // Drain, then give a stray extra beat time to show up.
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0)
         $display("trial_division_prime_test regression: pass");
      else
         $display("trial_division_prime_test regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_datapath.sv
hw/rtl/tdpt_ctrl.sv
hw/rtl/trial_division_prime_test.sv
bench/tb.sv
